// File: hw/rtl/ycr_pkg.sv
// Shared types and constants for the YCbCr 4:2:0 to RGBA converter.
// Used by the front end, the queue, the back end and the top level.
// Depends on nothing.
package ycr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    localparam int CHROMA_AW = 6;

    localparam logic [7:0] Y_BIAS    = 8'd16;
    localparam logic [7:0] ALPHA_OUT = 8'h80;
    localparam logic [7:0] CH_MAX    = 8'd255;

    localparam logic [15:0]       K_Y    = 16'h0095;
    localparam logic signed [17:0] K_R_CR = 18'sd204;
    localparam logic signed [17:0] K_G_CR = -18'sd104;
    localparam logic signed [17:0] K_G_CB = -18'sd50;
    localparam logic signed [17:0] K_B_CB = 18'sd258;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } conv_item_t;

endpackage

// File: hw/rtl/ycr_front.sv
// Front end: accepts transfers, stores chroma pairs and looks up the pair for each luma sample.
// Depends on ycr_pkg.
module ycr_front #(
    parameter int QUEUE_DEPTH = ycr_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // column, row, luma, blue_diff, red_diff
    input  logic                               s_tuser,  // func
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
    output logic                               push_valid,
    output ycr_pkg::conv_item_t                push_item
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [3:0]  column;
    logic [3:0]  row;
    logic [7:0]  luma;
    logic [7:0]  blue_diff;
    logic [7:0]  red_diff;
    logic        accept;
    logic        load;
    logic        convert;
    logic [ycr_pkg::CHROMA_AW-1:0] wr_addr;
    logic [ycr_pkg::CHROMA_AW-1:0] rd_addr;
    logic [COUNT_W:0] in_flight;

    logic [15:0] chroma_mem [2**ycr_pkg::CHROMA_AW];
    logic [15:0] rd_data_reg;
    logic [7:0]  luma_reg;
    logic        valid_reg;
    logic        valid_next;

    assign column    = s_tdata[3:0];
    assign row       = s_tdata[7:4];
    assign luma      = s_tdata[15:8];
    assign blue_diff = s_tdata[23:16];
    assign red_diff  = s_tdata[31:24];

    assign in_flight = {1'b0, queue_count} + (COUNT_W + 1)'(valid_reg);
    assign s_tready  = in_flight < (COUNT_W + 1)'(QUEUE_DEPTH);
    assign accept    = s_tvalid && s_tready;
    assign load      = accept && (s_tuser == ycr_pkg::FUNC_LOAD);
    assign convert   = accept && (s_tuser == ycr_pkg::FUNC_CONVERT);
    assign wr_addr   = {row[2:0], column[2:0]};
    assign rd_addr   = {row[3:1], column[3:1]};
    assign valid_next = convert;

    always_ff @(posedge aclk) begin
        if (load) begin
            chroma_mem[wr_addr] <= {red_diff, blue_diff};
        end
        rd_data_reg <= chroma_mem[rd_addr];
        luma_reg    <= luma;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign push_valid     = valid_reg;
    assign push_item.luma = luma_reg;
    assign push_item.cb   = rd_data_reg[7:0];
    assign push_item.cr   = rd_data_reg[15:8];

endmodule

// File: hw/rtl/ycr_queue.sv
// Short queue between the front end and the back end.
// Depends on ycr_pkg.
module ycr_queue #(
    parameter int QUEUE_DEPTH = ycr_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push_valid,
    input  ycr_pkg::conv_item_t                push_item,
    input  logic                               pop,
    output logic                               head_valid,
    output ycr_pkg::conv_item_t                head_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    ycr_pkg::conv_item_t slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid  = (count_reg != '0);
    assign head_item   = slot_reg[rd_ptr_reg];
    assign queue_count = count_reg;

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && !pop |-> count_reg != COUNT_W'(QUEUE_DEPTH))
        else $error("Queue written while full.");

    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("Queue read while empty.");

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

endmodule

// File: hw/rtl/ycr_back.sv
// Back end: two-stage colour conversion pipeline with a registered output transfer.
// Depends on ycr_pkg.
module ycr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  ycr_pkg::conv_item_t head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata  // red, green, blue, alpha
);

    function automatic logic [7:0] clamp_channel(input logic signed [11:0] sum);
        logic signed [11:0] rounded;
        logic signed [10:0] half;
        rounded = sum + 12'sd1;
        half    = rounded[11:1];
        if (half[10]) begin
            return 8'd0;
        end else if (half > 11'sd255) begin
            return ycr_pkg::CH_MAX;
        end
        return half[7:0];
    endfunction

    logic [7:0]          ly;
    logic [15:0]         lum_prod;
    logic signed [7:0]   cb_s;
    logic signed [7:0]   cr_s;
    logic signed [17:0]  cb_x;
    logic signed [17:0]  cr_x;
    logic signed [17:0]  rcr_prod;
    logic signed [17:0]  gcr_prod;
    logic signed [17:0]  gcb_prod;
    logic signed [17:0]  bcb_prod;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic signed [11:0]  lum_reg;
    logic signed [11:0]  rcr_reg;
    logic signed [11:0]  gcr_reg;
    logic signed [11:0]  gcb_reg;
    logic signed [11:0]  bcb_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          red_reg;
    logic [7:0]          green_reg;
    logic [7:0]          blue_reg;

    logic                out_ready;
    logic                a_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign pop       = head_valid && a_ready;

    assign ly       = (head_item.luma < ycr_pkg::Y_BIAS) ? 8'd0 : head_item.luma - ycr_pkg::Y_BIAS;
    assign lum_prod = {8'd0, ly} * ycr_pkg::K_Y;
    assign cb_s     = {~head_item.cb[7], head_item.cb[6:0]};
    assign cr_s     = {~head_item.cr[7], head_item.cr[6:0]};
    assign cb_x     = {{10{cb_s[7]}}, cb_s};
    assign cr_x     = {{10{cr_s[7]}}, cr_s};
    assign rcr_prod = ycr_pkg::K_R_CR * cr_x;
    assign gcr_prod = ycr_pkg::K_G_CR * cr_x;
    assign gcb_prod = ycr_pkg::K_G_CB * cb_x;
    assign bcb_prod = ycr_pkg::K_B_CB * cb_x;

    assign a_valid_next   = a_ready ? head_valid : a_valid_reg;
    assign out_valid_next = out_ready ? a_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            lum_reg <= {2'b00, lum_prod[15:6]};
            rcr_reg <= rcr_prod[17:6];
            gcr_reg <= gcr_prod[17:6];
            gcb_reg <= gcb_prod[17:6];
            bcb_reg <= bcb_prod[17:6];
        end
        if (out_ready && a_valid_reg) begin
            red_reg   <= clamp_channel(lum_reg + rcr_reg);
            green_reg <= clamp_channel(lum_reg + gcr_reg + gcb_reg);
            blue_reg  <= clamp_channel(lum_reg + bcb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ycr_pkg::ALPHA_OUT, blue_reg, green_reg, red_reg};

endmodule

// File: hw/rtl/ycbcr420_to_rgba_converter.sv
// Top level of the YCbCr 4:2:0 to RGBA converter for one 16x16 macroblock.
// A luma transfer passes the front-end lookup register, the queue, the back-end product register
// and the output register in turn before it sets m_tvalid.
// Throughput: one transfer per cycle unless the queue fills under m_tready back-pressure; the
// QUEUE_DEPTH entry queue lets input run ahead. A chroma load transfer gives no output transfer.
// Reset is synchronous and active low; it empties the pipeline and queue, not the chroma store.
// Depends on ycr_pkg, ycr_front, ycr_queue and ycr_back.
module ycbcr420_to_rgba_converter #(
    parameter int QUEUE_DEPTH = ycr_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // column, row, luma, blue_diff, red_diff
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red, green, blue, alpha
);

    logic                                push_valid;
    ycr_pkg::conv_item_t                 push_item;
    logic                                pop;
    logic                                head_valid;
    ycr_pkg::conv_item_t                 head_item;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_count;

    ycr_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_count(queue_count),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    ycr_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .queue_count(queue_count)
    );

    ycr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
